>>> rtl/core/gcd_lcm_unit_assert.svh
// ----------------------------------------------------------------------------
// gcd_lcm_unit_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_ASSERT_SVH
`define GCD_LCM_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GLU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/glu_pkg.sv
// ----------------------------------------------------------------------------
// glu_pkg
// shared width, datapath op codes, controller states and status bundle
// ----------------------------------------------------------------------------
package glu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,           // capture operands, form magnitudes
    DP_SET_G_X,        // gcd is x
    DP_SET_G_Y,        // gcd is y
    DP_START_YX,       // start y mod x
    DP_WB_Y_START_XY,  // y = remainder, start x mod y
    DP_WB_X_START_YX,  // x = remainder, start y mod x
    DP_START_AG,       // start |a| / g
    DP_STEP,           // one restoring division step
    DP_OUT_G,
    DP_OUT_ZERO,
    DP_OUT_MUL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic x_zero;
    logic rem_zero;
    logic g_zero;
    logic div_last;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_MOD_Y,
    ST_CHK_Y,
    ST_MOD_X,
    ST_CHK_X,
    ST_FINISH,
    ST_DIV_Q,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/glu_datapath.sv
// ----------------------------------------------------------------------------
// glu_datapath
// operand registers, bit-serial restoring divider and the lcm multiplier
// ----------------------------------------------------------------------------
module glu_datapath (
  input  logic                                 clk,
  input  glu_pkg::dp_cmd_t                     cmd,
  input  logic signed [glu_pkg::DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [glu_pkg::DATA_WIDTH-1:0] in_operand_b,
  output glu_pkg::dp_status_t                  status,
  output logic signed [glu_pkg::DATA_WIDTH-1:0] out_result
);
  import glu_pkg::*;

  logic [DATA_WIDTH-1:0] amag_r, amag_nxt;
  logic [DATA_WIDTH-1:0] badj_r, badj_nxt;
  logic [DATA_WIDTH-1:0] x_r, x_nxt;
  logic [DATA_WIDTH-1:0] y_r, y_nxt;
  logic [DATA_WIDTH-1:0] g_r, g_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] result_r, result_nxt;

  logic [DATA_WIDTH-1:0] a_u, b_u, a_mag, b_mag;
  logic [DATA_WIDTH:0]   shifted;
  logic                  ge;

  assign a_u   = DATA_WIDTH'(in_operand_a);
  assign b_u   = DATA_WIDTH'(in_operand_b);
  // most negative value yields its own pattern, read unsigned as 2^(w-1)
  assign a_mag = a_u[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
  assign b_mag = b_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;

  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    amag_nxt   = amag_r;
    badj_nxt   = badj_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    g_nxt      = g_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    den_nxt    = den_r;
    cnt_nxt    = cnt_r;
    result_nxt = result_r;
    unique case (cmd.op)
      DP_NOP: begin
      end
      DP_LOAD: begin
        amag_nxt = a_mag;
        // sign of a folded into b, so the product carries both signs
        badj_nxt = a_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;
        x_nxt    = a_mag;
        y_nxt    = b_mag;
      end
      DP_SET_G_X: g_nxt = x_r;
      DP_SET_G_Y: g_nxt = y_r;
      DP_START_YX: begin
        rem_nxt = '0;
        quo_nxt = y_r;
        den_nxt = x_r;
        cnt_nxt = '0;
      end
      DP_WB_Y_START_XY: begin
        y_nxt   = rem_r;
        rem_nxt = '0;
        quo_nxt = x_r;
        den_nxt = rem_r;
        cnt_nxt = '0;
      end
      DP_WB_X_START_YX: begin
        x_nxt   = rem_r;
        rem_nxt = '0;
        quo_nxt = y_r;
        den_nxt = rem_r;
        cnt_nxt = '0;
      end
      DP_START_AG: begin
        rem_nxt = '0;
        quo_nxt = amag_r;
        den_nxt = g_r;
        cnt_nxt = '0;
      end
      DP_STEP: begin
        rem_nxt = ge ? DATA_WIDTH'(shifted - {1'b0, den_r}) : shifted[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      DP_OUT_G:    result_nxt = g_r;
      DP_OUT_ZERO: result_nxt = '0;
      DP_OUT_MUL:  result_nxt = quo_r * badj_r;  // low word only, wraps
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    amag_r   <= amag_nxt;
    badj_r   <= badj_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    g_r      <= g_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    den_r    <= den_nxt;
    cnt_r    <= cnt_nxt;
    result_r <= result_nxt;
  end

  assign status.x_zero   = (x_r == '0);
  assign status.rem_zero = (rem_r == '0);
  assign status.g_zero   = (g_r == '0);
  assign status.div_last = (cnt_r == CNT_W'(DATA_WIDTH - 1));
  assign out_result      = result_r;

endmodule

>>> rtl/core/glu_ctrl.sv
// ----------------------------------------------------------------------------
// glu_ctrl
// sequencer for euclid's loop, the lcm divide and the result strobe
// ----------------------------------------------------------------------------
module glu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_command,
  input  glu_pkg::dp_status_t status,
  output glu_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                out_valid
);
  import glu_pkg::*;

  state_t state_r, state_nxt;
  logic   lcm_r, lcm_nxt;
  logic   accept;

  assign accept  = start && !busy;
  assign lcm_nxt = accept ? in_command : lcm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lcm_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lcm_r   <= lcm_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE, ST_DONE: begin
        state_nxt = accept ? ST_FIRST : ST_IDLE;
      end
      ST_FIRST:  state_nxt = status.x_zero ? ST_FINISH : ST_MOD_Y;
      ST_MOD_Y:  if (status.div_last) state_nxt = ST_CHK_Y;
      ST_CHK_Y:  state_nxt = status.rem_zero ? ST_FINISH : ST_MOD_X;
      ST_MOD_X:  if (status.div_last) state_nxt = ST_CHK_X;
      ST_CHK_X:  state_nxt = status.rem_zero ? ST_FINISH : ST_MOD_Y;
      ST_FINISH: begin
        if (lcm_r && !status.g_zero) state_nxt = ST_DIV_Q;
        else                         state_nxt = ST_DONE;
      end
      ST_DIV_Q:  if (status.div_last) state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op    = DP_NOP;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE, ST_DONE: begin
        busy      = 1'b0;
        out_valid = (state_r == ST_DONE);
        if (start) cmd.op = DP_LOAD;
      end
      ST_FIRST:  cmd.op = status.x_zero ? DP_SET_G_Y : DP_START_YX;
      ST_MOD_Y:  cmd.op = DP_STEP;
      // remainder of y mod x now in the divider
      ST_CHK_Y:  cmd.op = status.rem_zero ? DP_SET_G_X : DP_WB_Y_START_XY;
      ST_MOD_X:  cmd.op = DP_STEP;
      ST_CHK_X:  cmd.op = status.rem_zero ? DP_SET_G_Y : DP_WB_X_START_YX;
      ST_FINISH: begin
        if (!lcm_r)             cmd.op = DP_OUT_G;
        else if (status.g_zero) cmd.op = DP_OUT_ZERO;
        else                    cmd.op = DP_START_AG;
      end
      ST_DIV_Q:  cmd.op = DP_STEP;
      ST_MUL:    cmd.op = DP_OUT_MUL;
      default: begin
        cmd.op = DP_NOP;
      end
    endcase
  end

endmodule

>>> rtl/core/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// gcd or lcm of two signed operands: euclid on magnitudes, then (a/g)*b
// ----------------------------------------------------------------------------
// sequence from start to strobe: load, euclid's remainder steps on the magnitudes,
//   then for lcm when the gcd is nonzero the divide |a|/g and the multiply
// each remainder or quotient is formed in the one bit-serial divider
// a new start is not taken while busy; one is taken in the strobe cycle
// the strobe lasts one cycle, the receiver cannot stall
// reset: synchronous active-low rst_n returns the sequencer to idle
module gcd_lcm_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_command,
  input  logic signed [glu_pkg::DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [glu_pkg::DATA_WIDTH-1:0] in_operand_b,
  output logic                                 out_valid,
  output logic signed [glu_pkg::DATA_WIDTH-1:0] out_result
);
  import glu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  glu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  glu_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .status       (status),
    .out_result   (out_result)
  );

endmodule

>>> rtl/core/gcd_lcm_unit_checker.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit_checker
// port-level timing checks on the start/busy and result strobe beats
// ----------------------------------------------------------------------------
`include "gcd_lcm_unit_assert.svh"

module gcd_lcm_unit_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `GLU_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `GLU_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised after accepted beat")
  `GLU_ASSERT_NEXT(a_no_instant_result, start && !busy, !out_valid, "result right after accept")
  `GLU_ASSERT_NEXT(a_no_spurious, !busy && !out_valid, !out_valid, "result with no beat pending")

endmodule

bind gcd_lcm_unit gcd_lcm_unit_checker u_checker (.*);

>>> tb/gcd_lcm_unit_tb.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit_tb
// Self-checking bench for the gcd / lcm unit. Each accepted operand pair is
// run through a bit-accurate predictor, and the expected word is queued. Every
// result strobe is checked in order against that queue. The stimulus is a
// directed set of corner cases followed by randomly mixed operand shapes,
// with random idle cycles on the command side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_lcm_unit_tb;

  localparam int W = glu_pkg::DATA_WIDTH;

  localparam logic CMD_GCD = 1'b0;
  localparam logic CMD_LCM = 1'b1;

  localparam int RANDOM_PAIRS  = 1150;
  localparam int DRAIN_CYCLES  = 1700;
  localparam int MAX_REPORTS   = 10;

  typedef logic [W-1:0] word_t;

  localparam word_t MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam word_t MOST_POS = {1'b0, {(W-1){1'b1}}};

  typedef struct {
    logic  cmd;
    word_t a;
    word_t b;
    word_t expected;
  } pair_t;

  class gcd_lcm_ledger;
    pair_t       awaiting[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned gcd_pairs;
    int unsigned lcm_pairs;
    int unsigned zero_pairs;
    int unsigned most_neg_pairs;

    function word_t magnitude_of(word_t v);
      return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // euclid with remainders taken alternately in each direction
    function word_t gcd_of(word_t x, word_t y);
      while (x != '0 && y != '0) begin
        y = y % x;
        if (y != '0) x = x % y;
      end
      return (x == '0) ? y : x;
    endfunction

    function word_t gcd_or_lcm(logic cmd, word_t a, word_t b);
      word_t g;
      word_t q;
      g = gcd_of(magnitude_of(a), magnitude_of(b));
      if (cmd == CMD_GCD) return g;
      if (g == '0) return '0;
      q = magnitude_of(a) / g;
      if (a[W-1]) q = ~q + 1'b1;
      return q * b;
    endfunction

    function void note_pair(logic cmd, word_t a, word_t b);
      pair_t p;
      p.cmd      = cmd;
      p.a        = a;
      p.b        = b;
      p.expected = gcd_or_lcm(cmd, a, b);
      awaiting.push_back(p);
      if (cmd == CMD_GCD) gcd_pairs++;
      else lcm_pairs++;
      if (a == '0 || b == '0) zero_pairs++;
      if (a == MOST_NEG || b == MOST_NEG) most_neg_pairs++;
    endfunction

    function void check_result(word_t r);
      pair_t p;
      if (awaiting.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %h with no pair outstanding", $realtime, r);
        return;
      end
      p = awaiting.pop_front();
      checked++;
      if (r !== p.expected) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s a=%h b=%h expected %h got %h", $realtime,
                   (p.cmd == CMD_GCD) ? "gcd" : "lcm", p.a, p.b, p.expected, r);
      end
    endfunction

    function int unsigned pending();
      return awaiting.size();
    endfunction
  endclass

  logic  clk   = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  logic  in_command = CMD_GCD;
  word_t in_operand_a = '0;
  word_t in_operand_b = '0;
  logic  out_valid;
  word_t out_result;

  gcd_lcm_ledger ledger;
  bit            idle_on = 1'b1;

  always #5 clk = ~clk;

  gcd_lcm_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_result   (out_result)
  );

  // an x on the strobe counts as a result too
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) ledger.check_result(out_result);
  end

  task automatic send_pair(logic cmd, word_t a, word_t b);
    bit offered;
    do begin
      // offer the beat, or idle this cycle with junk on the fields
      offered = !(idle_on && $urandom_range(99) < 9);
      start <= offered;
      if (offered) begin
        in_command   <= cmd;
        in_operand_a <= a;
        in_operand_b <= b;
      end else begin
        in_command   <= 1'($urandom_range(1));
        in_operand_a <= word_t'($urandom());
        in_operand_b <= word_t'($urandom());
      end
      @(posedge clk);
    end while (!(offered && !busy));
    ledger.note_pair(cmd, a, b);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  initial begin
    word_t a;
    word_t b;
    word_t t;
    int    g;
    ledger = new;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zeros, sign combinations, most negative and most positive, long euclid
    send_pair(CMD_GCD, '0, '0);
    send_pair(CMD_LCM, '0, '0);
    send_pair(CMD_GCD, '0, word_t'(-15));
    send_pair(CMD_GCD, word_t'(-15), '0);
    send_pair(CMD_LCM, '0, word_t'(5));
    send_pair(CMD_LCM, word_t'(5), '0);
    send_pair(CMD_GCD, MOST_NEG, '0);
    send_pair(CMD_GCD, MOST_NEG, MOST_NEG);
    send_pair(CMD_LCM, MOST_NEG, MOST_NEG);
    send_pair(CMD_GCD, MOST_NEG, word_t'(6));
    send_pair(CMD_LCM, MOST_NEG, word_t'(-3));
    send_pair(CMD_GCD, MOST_POS, MOST_POS);
    send_pair(CMD_LCM, MOST_POS, MOST_POS - 1'b1);
    send_pair(CMD_LCM, MOST_POS, MOST_NEG);
    send_pair(CMD_GCD, word_t'(-12), word_t'(18));
    send_pair(CMD_LCM, word_t'(-4), word_t'(6));
    send_pair(CMD_LCM, word_t'(4), word_t'(-6));
    send_pair(CMD_LCM, word_t'(-4), word_t'(-6));
    send_pair(CMD_LCM, word_t'(1), word_t'(-1));
    send_pair(CMD_GCD, word_t'(1), word_t'(1));
    send_pair(CMD_GCD, word_t'(1836311903), word_t'(1134903170));
    send_pair(CMD_LCM, word_t'(1134903170), word_t'(-1836311903));
    send_pair(CMD_GCD, '1, '1);
    hold_until_drained();

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      idle_on = !(i >= 300 && i < 550);
      if (i == 700) hold_until_drained();
      case ($urandom_range(9))
        0, 1, 2: begin
          a = word_t'($urandom());
          b = word_t'($urandom());
        end
        3, 4: begin
          a = word_t'(int'($urandom_range(2000)) - 1000);
          b = word_t'(int'($urandom_range(2000)) - 1000);
        end
        5, 6: begin
          // shared factor, so the gcd is a multiple of g, though the lcm can still wrap
          g = int'($urandom_range(5000, 1));
          a = word_t'(g * (int'($urandom_range(120000)) - 60000));
          b = word_t'(g * (int'($urandom_range(120000)) - 60000));
        end
        7: begin
          a = word_t'($urandom());
          case ($urandom_range(4))
            0:       b = '0;
            1:       b = MOST_NEG;
            2:       b = MOST_POS;
            3:       b = word_t'(1);
            default: b = '1;
          endcase
          if ($urandom_range(1)) begin
            t = a;
            a = b;
            b = t;
          end
        end
        8: begin
          a = word_t'(int'(shortint'($urandom())));
          b = word_t'(int'(shortint'($urandom())));
        end
        default: begin
          a = word_t'(int'($urandom_range(2097152)) - 1048576);
          b = word_t'(int'($urandom_range(2097152)) - 1048576);
        end
      endcase
      send_pair(logic'($urandom_range(1)), a, b);
    end

    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d gcd and %0d lcm pairs, %0d with a zero operand,",
             ledger.gcd_pairs, ledger.lcm_pairs, ledger.zero_pairs);
    $display("  %0d with the most negative; %0d results checked, %0d mismatches, %0d missing",
             ledger.most_neg_pairs, ledger.checked, ledger.mismatches, ledger.pending());
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("timeout with %0d results outstanding", ledger.pending());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/glu_pkg.sv
rtl/core/glu_datapath.sv
rtl/core/glu_ctrl.sv
rtl/core/gcd_lcm_unit.sv
rtl/core/gcd_lcm_unit_checker.sv
tb/gcd_lcm_unit_tb.sv
